[design/mfdu_pkg.sv]
// mfdu_pkg: shared types and constants for the motor feedback decode and unwrap block
// used by mfdu_front, mfdu_back and motor_feedback_decode_unwrap_core
// no dependencies
package mfdu_pkg;

    // motor map
    localparam int MOTORS_PER_BUS = 8;
    localparam int BUS_COUNT      = 2;
    localparam int SLOT_COUNT     = MOTORS_PER_BUS * BUS_COUNT;
    localparam int SLOT_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [10:0] MOTOR_ID_BASE = 11'h201;

    // encoder turn constants, diff is 17 bits signed
    localparam logic signed [16:0] HALF_TURN     = 17'sd4096;
    localparam logic signed [16:0] NEG_HALF_TURN = -17'sd4096;
    localparam logic signed [16:0] FULL_TURN     = 17'sd8192;

    // queue sizing for both internal queues
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // frame status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    // received frame
    typedef struct packed {
        logic        bus_select;
        logic [10:0] std_id;
        logic [7:0]  rx_byte0;
        logic [7:0]  rx_byte1;
        logic [7:0]  rx_byte2;
        logic [7:0]  rx_byte3;
        logic [7:0]  rx_byte4;
        logic [7:0]  rx_byte5;
        logic [7:0]  rx_byte6;
    } frame_t;

    // decoded frame handed from front to back
    typedef struct packed {
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       angle;
        logic [15:0]       speed;
        logic [15:0]       current;
        logic [7:0]        temp;
    } cmd_t;

    // result item
    typedef struct packed {
        logic [3:0]         motor_slot;
        logic               frame_status;
        logic [15:0]        rotor_angle;
        logic signed [15:0] rotor_speed;
        logic signed [15:0] phase_current;
        logic [7:0]         motor_temp;
        logic signed [31:0] multiturn_angle;
    } result_t;

endpackage

[design/mfdu_front.sv]
// mfdu_front: accepts frames, decodes the payload and classifies the motor slot
// holds decoded requests in a short queue for mfdu_back; uses mfdu_pkg
module mfdu_front
    import mfdu_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  frame_t frame,
    output logic   cmd_valid,
    output cmd_t   cmd,
    input  logic   cmd_take
);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push_ok;
    logic              take_ok;
    logic [10:0]       offset;
    logic              in_range;
    cmd_t              decoded;

    // slot classification: identifier offset wraps in 11 bits, so low ids fall out of range
    always_comb
    begin
        offset   = frame.std_id - MOTOR_ID_BASE;
        in_range = (offset < 11'(MOTORS_PER_BUS))
                && (32'(frame.bus_select) < 32'(BUS_COUNT));
        decoded.slot_ok = in_range;
        decoded.slot    = SLOT_W'(SLOT_W'(frame.bus_select) * SLOT_W'(MOTORS_PER_BUS))
                        + SLOT_W'(offset);
        decoded.angle   = {frame.rx_byte0, frame.rx_byte1};
        decoded.speed   = {frame.rx_byte2, frame.rx_byte3};
        decoded.current = {frame.rx_byte4, frame.rx_byte5};
        decoded.temp    = frame.rx_byte6;
    end

    // queue handshake
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign take_ok   = cmd_take && cmd_valid;

    // pointer and count updates
    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_ok) - QCNT_W'(take_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

    // queue occupancy stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("front queue overfilled");

    // occupancy matches pointer distance
    assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("front queue pointers disagree with count");

    // a stored request appears at the head when the queue was empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !cmd_valid) |=> (cmd_valid && cmd == $past(decoded)))
        else $error("front queue lost a request");

endmodule

[design/mfdu_back.sv]
// mfdu_back: per-motor angle unwrap and multi-turn accumulation, result queue
// takes decoded requests from mfdu_front; uses mfdu_pkg
module mfdu_back
    import mfdu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_take,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    logic [15:0]        prev_reg  [SLOT_COUNT];
    logic [31:0]        total_reg [SLOT_COUNT];
    result_t            res_q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               res_full;
    logic               pop_ok;
    logic signed [16:0] diff_raw;
    logic signed [16:0] diff;
    logic [31:0]        total_new;
    result_t            res_new;

    // result queue handshake
    assign res_full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign result   = res_q_reg[rd_ptr_reg];
    assign pop_ok   = pop && !empty;
    assign cmd_take = cmd_valid && !res_full;

    // unwrap the angle step against the stored angle, then accumulate
    always_comb
    begin
        diff_raw = $signed({1'b0, cmd.angle}) - $signed({1'b0, prev_reg[cmd.slot]});
        if (diff_raw < NEG_HALF_TURN)
        begin
            diff = diff_raw + FULL_TURN;
        end
        else if (diff_raw > HALF_TURN)
        begin
            diff = diff_raw - FULL_TURN;
        end
        else
        begin
            diff = diff_raw;
        end
        total_new = total_reg[cmd.slot] + 32'(diff);
    end

    // build the result item, dropped frames report slot and total as zero
    always_comb
    begin
        res_new.rotor_angle   = cmd.angle;
        res_new.rotor_speed   = $signed(cmd.speed);
        res_new.phase_current = $signed(cmd.current);
        res_new.motor_temp    = cmd.temp;
        if (cmd.slot_ok)
        begin
            res_new.motor_slot      = 4'(cmd.slot);
            res_new.frame_status    = STATUS_OK;
            res_new.multiturn_angle = $signed(total_new);
        end
        else
        begin
            res_new.motor_slot      = '0;
            res_new.frame_status    = STATUS_DROP;
            res_new.multiturn_angle = '0;
        end
    end

    // per-motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                prev_reg[i]  <= '0;
                total_reg[i] <= '0;
            end
        end
        else if (cmd_take && cmd.slot_ok)
        begin
            prev_reg[cmd.slot]  <= cmd.angle;
            total_reg[cmd.slot] <= total_new;
        end
    end

    // result queue pointers
    always_comb
    begin
        wr_ptr_next = cmd_take ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(cmd_take) - QCNT_W'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            res_q_reg[wr_ptr_reg] <= res_new;
        end
    end

    // a taken in-range request leaves its angle as the stored previous angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.slot_ok) |=> (prev_reg[$past(cmd.slot)] == $past(cmd.angle)))
        else $error("previous angle not updated");

    // dropped requests leave the multi-turn total untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && !cmd.slot_ok) |=>
            (total_reg[$past(cmd.slot)] == $past(total_reg[cmd.slot])))
        else $error("dropped frame changed motor state");

    // result queue occupancy stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

endmodule

[design/motor_feedback_decode_unwrap_core.sv]
// motor_feedback_decode_unwrap_core: top level of the motor feedback decoder
// instantiates mfdu_front and mfdu_back; uses mfdu_pkg
//
// Usage
//   Input channel: a frame request is taken at a rising edge with push high and
//   full low. Result channel: while empty is low the oldest result sits on
//   result; it is taken at a rising edge with pop high.
//   Every frame gives exactly one result, in arrival order. Frames whose
//   identifier lies outside the motor range come back with frame_status set,
//   slot and multi-turn angle zero, and leave the motor state alone.
//   Path: a taken frame is stored in the front queue, then passes through the
//   per-motor update into the result queue once that queue has room; only then
//   can its result be popped.
//   Throughput: one frame per cycle while pop keeps the result queue from filling;
//   the per-motor read-modify-write of the stored angle and total is combinational.
//   Reset: clears both queues and sets every stored angle and total to zero.
//   Stalls: if pop stays low the four-entry result queue fills, then the
//   four-entry front queue, after which full rises; nothing is lost.
module motor_feedback_decode_unwrap_core
    import mfdu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  frame_t  frame,
    input  logic    pop,
    output logic    empty,
    output result_t result
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    // decode and classify
    mfdu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .frame     (frame),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // unwrap and accumulate
    mfdu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

[tb/motor_feedback_decode_unwrap_core_tb.sv]
// motor_feedback_decode_unwrap_core_tb: self-checking testbench for the motor feedback decoder
// predicts decoded fields and per-motor multi-turn totals, checks every result in order
// depends on mfdu_pkg and motor_feedback_decode_unwrap_core
module motor_feedback_decode_unwrap_core_tb;
    import mfdu_pkg::*;

    localparam int RANDOM_FRAMES  = 1300;
    localparam int CLIMB_SLOT     = 2;
    localparam int CLIMB_FRAMES   = 64;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 3_000_000;

    logic    clk;
    logic    rst_n;
    logic    push;
    logic    full;
    frame_t  frame;
    logic    pop;
    logic    empty;
    result_t result;

    // predicted per-motor state
    logic [15:0] last_angle [SLOT_COUNT];
    logic [31:0] turn_total [SLOT_COUNT];

    result_t     pending_feedback [$];
    int          mismatch_count;
    bit          stall_enable;
    int unsigned pop_hold;

    motor_feedback_decode_unwrap_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .frame  (frame),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    // clock
    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic frame_t make_frame(input logic bus, input logic [10:0] id,
                                          input logic [15:0] angle, input logic [15:0] speed,
                                          input logic [15:0] current, input logic [7:0] temp);
        frame_t f;
        f.bus_select = bus;
        f.std_id     = id;
        f.rx_byte0   = angle[15:8];
        f.rx_byte1   = angle[7:0];
        f.rx_byte2   = speed[15:8];
        f.rx_byte3   = speed[7:0];
        f.rx_byte4   = current[15:8];
        f.rx_byte5   = current[7:0];
        f.rx_byte6   = temp;
        return f;
    endfunction

    function automatic frame_t random_frame();
        return make_frame(1'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 8'($urandom));
    endfunction

    // decode one frame and advance the predicted state of its motor
    function automatic result_t decode_and_unwrap(input frame_t f);
        result_t     r;
        logic [31:0] offset;
        int          slot;
        int          delta;
        int          new_angle;
        int          old_angle;
        r.rotor_angle     = {f.rx_byte0, f.rx_byte1};
        r.rotor_speed     = {f.rx_byte2, f.rx_byte3};
        r.phase_current   = {f.rx_byte4, f.rx_byte5};
        r.motor_temp      = f.rx_byte6;
        r.motor_slot      = '0;
        r.frame_status    = STATUS_DROP;
        r.multiturn_angle = '0;
        offset = {21'd0, f.std_id} - {21'd0, MOTOR_ID_BASE};
        if (offset < 32'(MOTORS_PER_BUS) && 32'(f.bus_select) < 32'(BUS_COUNT))
        begin
            slot      = int'(f.bus_select) * MOTORS_PER_BUS + int'(offset);
            new_angle = r.rotor_angle;
            old_angle = last_angle[slot];
            delta     = new_angle - old_angle;
            // take the short way round the encoder circle
            if (delta < int'(NEG_HALF_TURN))
                delta = delta + int'(FULL_TURN);
            else if (delta > int'(HALF_TURN))
                delta = delta - int'(FULL_TURN);
            last_angle[slot]  = r.rotor_angle;
            turn_total[slot]  = turn_total[slot] + 32'(delta);
            r.motor_slot      = 4'(slot);
            r.frame_status    = STATUS_OK;
            r.multiturn_angle = turn_total[slot];
        end
        return r;
    endfunction

    // send one frame request, predict its result once taken
    task automatic push_frame(input frame_t f);
        int unsigned gap;
        gap = stall_enable ? idle_length() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            push  <= 1'b0;
            frame <= random_frame();
            repeat (gap) @(negedge clk);
        end
        push  <= 1'b1;
        frame <= f;
        @(posedge clk);
        while (full) @(posedge clk);
        pending_feedback.push_back(decode_and_unwrap(f));
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%h, got 0x%h", name, want, got);
            mismatch_count++;
        end
    endtask

    // result side stalls
    always @(negedge clk)
    begin
        if (stall_enable && pop_hold != 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
        begin
            pop <= 1'b1;
            if (stall_enable)
                pop_hold = idle_length();
        end
    end

    // check each result taken against the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_feedback.size() == 0)
            begin
                $error("result with no frame pending, motor_slot 0x%h", result.motor_slot);
                mismatch_count++;
            end
            else
            begin
                want = pending_feedback.pop_front();
                compare_field("motor_slot", 32'(want.motor_slot), 32'(result.motor_slot));
                compare_field("frame_status", 32'(want.frame_status),
                              32'(result.frame_status));
                compare_field("rotor_angle", 32'(want.rotor_angle), 32'(result.rotor_angle));
                compare_field("rotor_speed", 32'(want.rotor_speed), 32'(result.rotor_speed));
                compare_field("phase_current", 32'(want.phase_current),
                              32'(result.phase_current));
                compare_field("motor_temp", 32'(want.motor_temp), 32'(result.motor_temp));
                compare_field("multiturn_angle", want.multiturn_angle,
                              result.multiturn_angle);
            end
        end
    end

    // first frames after reset and the half-turn thresholds, both buses
    task automatic test_unwrap_thresholds();
        push_frame(make_frame(1'b0, MOTOR_ID_BASE, 16'h1000, 16'h7FFF, 16'h8000, 8'hFF));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE, 16'h0000, 16'h8000, 16'h7FFF, 8'h00));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE, 16'h1001, 16'hFFFF, 16'h0000, 8'h80));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE, 16'h0000, 16'h0001, 16'hFFFF, 8'h7F));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE, 16'hFFFF, 16'h0000, 16'h0001, 8'h01));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE, 16'h0000, 16'h5A5A, 16'hA5A5, 8'hFE));
        push_frame(make_frame(1'b1, MOTOR_ID_BASE + 11'd7, 16'hFFFF, 16'hFFFF, 16'h0001,
                              8'h55));
        push_frame(make_frame(1'b1, MOTOR_ID_BASE, 16'h1FFF, 16'h8000, 16'h7FFF, 8'hAA));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE + 11'd7, 16'h2000, 16'h0000, 16'h0000,
                              8'h00));
    endtask

    // identifiers just outside and far outside the motor range leave state alone
    task automatic test_out_of_range_ids();
        push_frame(make_frame(1'b0, MOTOR_ID_BASE - 11'd1, 16'h1234, 16'h8001, 16'h7FFE,
                              8'h12));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE + 11'd8, 16'hFEDC, 16'h0102, 16'hFFFE,
                              8'hC3));
        push_frame(make_frame(1'b0, 11'h000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
        push_frame(make_frame(1'b1, 11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        push_frame(make_frame(1'b1, MOTOR_ID_BASE - 11'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              8'hFF));
        push_frame(make_frame(1'b1, MOTOR_ID_BASE + 11'd8, 16'h8000, 16'h8000, 16'h8000,
                              8'h80));
        // same angle again: no change since the dropped frames
        push_frame(make_frame(1'b1, MOTOR_ID_BASE, 16'h1FFF, 16'h7FFF, 16'h8000, 8'h3C));
        push_frame(make_frame(1'b0, MOTOR_ID_BASE + 11'd3, 16'h0FFF, 16'h1111, 16'hEEEE,
                              8'h99));
    endtask

    // climb one motor by large steps and wide jumps, back to back
    task automatic test_long_climb();
        logic [15:0] angle;
        stall_enable = 1'b0;
        angle        = 16'hFFFF;
        repeat (CLIMB_FRAMES)
        begin
            push_frame(make_frame(1'b0, MOTOR_ID_BASE + 11'(CLIMB_SLOT), angle,
                                  16'($urandom), 16'($urandom), 8'($urandom)));
            // step down just over a half turn, then jump back to the top
            if (angle < 16'd4097)
                angle = 16'hFFFF;
            else
                angle = angle - 16'd4097;
        end
        repeat (4)
            push_frame(make_frame(1'b0, MOTOR_ID_BASE + 11'(CLIMB_SLOT), 16'($urandom),
                                  16'($urandom), 16'($urandom), 8'($urandom)));
        stall_enable = 1'b1;
    endtask

    // mostly plausible motion on valid motors, some foreign identifiers
    task automatic test_random_traffic();
        int          n;
        int          slot;
        int          step;
        int unsigned pick;
        logic        bus;
        logic [10:0] id;
        logic [15:0] angle;
        for (n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n % 100 == 0)
                stall_enable = ($urandom_range(0, 3) != 0);
            bus   = 1'($urandom);
            angle = 16'($urandom);
            if ($urandom_range(0, 99) < 85)
            begin
                slot = int'(bus) * MOTORS_PER_BUS + $urandom_range(0, MOTORS_PER_BUS - 1);
                id   = MOTOR_ID_BASE + 11'(slot % MOTORS_PER_BUS);
                pick = $urandom_range(0, 9);
                step = 0;
                if (pick >= 2 && pick <= 5)
                    step = $urandom_range(0, 16384) - 8192;
                else if (pick == 6 || pick == 7)
                    step = ($urandom_range(0, 1) ? 4096 : 4097) * ($urandom_range(0, 1) ? 1 : -1);
                else if (pick == 8)
                    step = ($urandom_range(0, 1) ? 8191 : 8192) * ($urandom_range(0, 1) ? 1 : -1);
                if (pick >= 2 && pick <= 8)
                    angle = 16'(int'(last_angle[slot]) + step);
                else if (pick == 9)
                    angle = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            else if ($urandom_range(0, 1))
                id = $urandom_range(0, 1) ? MOTOR_ID_BASE - 11'd1 : MOTOR_ID_BASE + 11'd8;
            else
                id = 11'($urandom);
            push_frame(make_frame(bus, id, angle, 16'($urandom), 16'($urandom),
                                  8'($urandom)));
        end
    endtask

    // run limit
    initial
    begin
        #(64'd8 * CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        frame          = '0;
        stall_enable   = 1'b1;
        pop_hold       = 0;
        mismatch_count = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            last_angle[s] = '0;
            turn_total[s] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_unwrap_thresholds();
        test_out_of_range_ids();
        test_long_climb();
        test_random_traffic();

        @(negedge clk);
        push <= 1'b0;
        while (pending_feedback.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
